// File: rtl/pbu_pkg.sv
// pbu_pkg: blend mode codes and fixed constants for the pixel blend unit.
// Used by pixel_blend_unit and pbu_checker; depends on nothing.
`timescale 1ns / 1ps

package pbu_pkg;

	localparam int unsigned PIX_W  = 8;
	localparam int unsigned FUNC_W = 3;
	localparam int unsigned WGT_W  = 9;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [WGT_W-1:0]  wgt_t;

	// blend mode selector codes
	localparam func_t FUNC_ADD    = 3'd0;
	localparam func_t FUNC_MUL    = 3'd1;
	localparam func_t FUNC_MIX    = 3'd2;
	localparam func_t FUNC_MAX    = 3'd3;
	localparam func_t FUNC_SHADE  = 3'd4;
	localparam func_t FUNC_MIXMAP = 3'd5;

	localparam wgt_t WGT_FULL  = 9'd256;
	localparam wgt_t WGT_RESET = 9'd128;
	localparam pix_t PIX_MAX   = 8'hFF;

endpackage

// File: rtl/pixel_blend_unit.sv
// pixel_blend_unit: two-pixel grey blender (add, multiply, mix, max, shade, mix by map).
// Depends on pbu_pkg.
`timescale 1ns / 1ps

// One beat in, one beat out. Every input beat holds a mode code, two 8-bit
// pixels and a per-pixel weight; the block returns one blended pixel and a
// flag that is set only when add mode saturated at 255. The data path is an
// input register (_s1) followed by a result register (_s2) with one level of
// small multipliers (8x9 at most) between them, so the block accepts a beat
// every cycle while in_stall is low. Each accepted beat is held in _s1 and
// its result is presented from _s2. Output stall propagates back to in_stall
// only when both stages are full. The fixed mix weight is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// as the block itself does not enforce this. Values above 256 are saturated
// to 256 at write time, and it resets to 128. Mode codes 6 and 7 give a zero
// pixel with the flag clear.
module pixel_blend_unit (
	input  logic                clk,
	input  logic                arst_n,
	// config
	input  logic                cfg_wr_en,
	input  pbu_pkg::wgt_t       cfg_wr_data,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  pbu_pkg::func_t      func,
	input  pbu_pkg::pix_t       pixel_a,
	input  pbu_pkg::pix_t       pixel_b,
	input  pbu_pkg::pix_t       map_weight,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output pbu_pkg::pix_t       pixel_out,
	output logic                clamped
);
	import pbu_pkg::*;

	// fixed mix weight, always held within 0..256
	wgt_t  mix_weight_q;

	// stage 1: captured input beat
	logic  valid_s1;
	func_t func_s1;
	pix_t  a_s1;
	pix_t  b_s1;
	pix_t  mw_s1;

	// stage 2: result register
	logic  valid_s2;
	pix_t  pix_s2;
	logic  clamped_s2;

	logic  adv;          // stage 2 can take a new result
	logic  take;         // input beat accepted

	// combinational blend terms
	wgt_t             w_sel;
	wgt_t             w_cmp;
	logic [16:0]      prod_aw;
	logic [16:0]      prod_bw;
	logic [PIX_W:0]   mix_sum;
	logic [15:0]      prod_ab;
	pix_t             sh_base;
	logic [14:0]      prod_sh;
	logic [PIX_W:0]   sh_hi;
	pix_t             shade_res;
	logic [PIX_W:0]   add_sum;
	pix_t             res_d;
	logic             clamped_d;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	// config register; saturate anything above full scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_weight_q <= WGT_RESET;
		end else if (cfg_wr_en) begin
			mix_weight_q <= (cfg_wr_data > WGT_FULL) ? WGT_FULL : cfg_wr_data;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			func_s1 <= func;
			a_s1    <= pixel_a;
			b_s1    <= pixel_b;
			mw_s1   <= map_weight;
		end
	end

	// mix: (a*w)>>8 + (b*(256-w))>>8, each product floored on its own
	assign w_sel   = (func_s1 == FUNC_MIXMAP) ? {1'b0, mw_s1} : mix_weight_q;
	assign w_cmp   = WGT_FULL - w_sel;
	assign prod_aw = {9'd0, a_s1} * {8'd0, w_sel};
	assign prod_bw = {9'd0, b_s1} * {8'd0, w_cmp};
	assign mix_sum = prod_aw[16:8] + prod_bw[16:8];

	assign prod_ab = {8'd0, a_s1} * {8'd0, b_s1};

	// shade: below mid, b*a>>7; at or above mid, (255-b)*(a-128)>>7 + b.
	// a-128 is just a[6:0] in the upper half, and 255-b is ~b.
	assign sh_base   = a_s1[7] ? ~b_s1 : b_s1;
	assign prod_sh   = {7'd0, sh_base} * {8'd0, a_s1[6:0]};
	assign sh_hi     = {1'b0, prod_sh[14:7]} + {1'b0, b_s1};
	assign shade_res = a_s1[7] ? sh_hi[PIX_W-1:0] : prod_sh[14:7];

	assign add_sum = {1'b0, a_s1} + {1'b0, b_s1};

	always_comb begin
		res_d     = '0;
		clamped_d = 1'b0;
		unique case (func_s1)
			FUNC_ADD: begin
				clamped_d = add_sum[PIX_W];
				res_d     = add_sum[PIX_W] ? PIX_MAX : add_sum[PIX_W-1:0];
			end
			FUNC_MUL: begin
				res_d = prod_ab[15:8];
			end
			FUNC_MIX, FUNC_MIXMAP: begin
				res_d = mix_sum[PIX_W-1:0];
			end
			FUNC_MAX: begin
				res_d = (a_s1 > b_s1) ? a_s1 : b_s1;
			end
			FUNC_SHADE: begin
				res_d = shade_res;
			end
			default: begin
				res_d     = '0;
				clamped_d = 1'b0;
			end
		endcase
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			pix_s2     <= res_d;
			clamped_s2 <= clamped_d;
		end
	end

	assign out_valid = valid_s2;
	assign pixel_out = pix_s2;
	assign clamped   = clamped_s2;

endmodule

// File: rtl/pbu_checker.sv
// pbu_checker: port-level checks for pixel_blend_unit, bound into pixel_blend_unit.
// Depends on pbu_pkg and pixel_blend_unit.
`timescale 1ns / 1ps

module pbu_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input pbu_pkg::pix_t       pixel_out,
	input logic                clamped
);
	import pbu_pkg::*;

	// a saturated add always shows full white
	a_clamp_white: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clamped |-> pixel_out == PIX_MAX)
		else $error("clamped beat without full-scale pixel");

	// input only backs up when the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without output backpressure");

	// no stall on the input while nothing waits on the output
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("in_stall with empty output");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(clamped))
		else $error("stalled output beat changed");

endmodule

bind pixel_blend_unit pbu_checker u_pbu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pixel_out (pixel_out),
	.clamped   (clamped)
);
